@@ sv/line_pixel_stepper_defines.svh @@
// Assertion macros shared by the line stepper modules.
// Each macro expects clk and rst_n in scope.
`ifndef LINE_PIXEL_STEPPER_DEFINES_SVH
`define LINE_PIXEL_STEPPER_DEFINES_SVH

// Check that a condition holds on every clock edge out of reset.
`define LPS_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Check that a consequent holds in the same cycle as its antecedent.
`define LPS_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

@@ sv/lps_pkg.sv @@
`timescale 1ns / 1ps

package lps_pkg;

    // Item opcodes
    localparam logic MODE_BEGIN = 1'b0;
    localparam logic MODE_NEXT  = 1'b1;

    // Classified command flags passed from front to back
    typedef struct packed {
        logic mode;
        logic x_major;
        logic x_down;
        logic y_down;
    } cmd_flags_t;

    // Result flags carried alongside the pixel coordinates
    typedef struct packed {
        logic valid;
        logic last;
    } res_flags_t;

endpackage

@@ sv/line_pixel_stepper.sv @@
`timescale 1ns / 1ps
// Channel | Handshake          | Fields
// input   | push / full        | mode, x_start, y_start, x_end, y_end
// result  | empty / pop        | pixel_x, pixel_y, pixel_valid, last_pixel
//
// One item per cycle sustained while the result queue has room; each item yields exactly one result.
// A result shows on empty low once it has passed the command queue, which takes the item
// when it is accepted, and then the result queue, which the stepper fills when it has room.
// The stepper's add, compare and subtract on the error term are combinational.
// Reset clears the line state and both queues; no line is active after reset.
// A held-off pop backs up the result queue, then the stepper, then full rises.

module line_pixel_stepper #(
    parameter int COORD_BITS  = 12,
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic                         mode,
    input  logic signed [COORD_BITS-1:0] x_start,
    input  logic signed [COORD_BITS-1:0] y_start,
    input  logic signed [COORD_BITS-1:0] x_end,
    input  logic signed [COORD_BITS-1:0] y_end,
    output logic                         empty,
    input  logic                         pop,
    output logic signed [COORD_BITS-1:0] pixel_x,
    output logic signed [COORD_BITS-1:0] pixel_y,
    output logic                         pixel_valid,
    output logic                         last_pixel
);

    localparam int N        = COORD_BITS;
    localparam int CMD_BITS = 4 * N + $bits(lps_pkg::cmd_flags_t);
    localparam int RES_BITS = 2 * N + $bits(lps_pkg::res_flags_t);
    localparam int RFB      = $bits(lps_pkg::res_flags_t);

    logic                cmd_empty, cmd_pop;
    logic [CMD_BITS-1:0] cmd_data;
    logic                res_full, res_push;
    logic [RES_BITS-1:0] res_wdata, res_rdata;
    lps_pkg::res_flags_t rflags;

    // Classify incoming items
    lps_front #(
        .COORD_BITS  (COORD_BITS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .mode      (mode),
        .x_start   (x_start),
        .y_start   (y_start),
        .x_end     (x_end),
        .y_end     (y_end),
        .cmd_pop   (cmd_pop),
        .cmd_empty (cmd_empty),
        .cmd_data  (cmd_data)
    );

    // Step the line at most one pixel per command
    lps_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_empty (cmd_empty),
        .cmd_data  (cmd_data),
        .cmd_pop   (cmd_pop),
        .res_full  (res_full),
        .res_push  (res_push),
        .res_data  (res_wdata)
    );

    // Hold results until the consumer pops them
    lps_queue #(
        .WIDTH (RES_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .wdata (res_wdata),
        .full  (res_full),
        .pop   (pop),
        .rdata (res_rdata),
        .empty (empty)
    );

    assign rflags      = lps_pkg::res_flags_t'(res_rdata[RES_BITS-1 -: RFB]);
    assign pixel_x     = res_rdata[2*N-1 -: N];
    assign pixel_y     = res_rdata[N-1:0];
    assign pixel_valid = rflags.valid;
    assign last_pixel  = rflags.last;

endmodule

@@ sv/lps_queue.sv @@
`timescale 1ns / 1ps
`include "line_pixel_stepper_defines.svh"

module lps_queue #(
    parameter int WIDTH = 52,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push & ~full;
    assign do_pop  = pop & ~empty;
    assign rdata   = slot_reg[rd_ptr_reg];

    // Advance pointers with wrap and track the fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold the item in its slot
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

    `LPS_ASSERT_ALWAYS(a_count_in_range, count_reg <= CW'(DEPTH), "queue over-filled")
    `LPS_ASSERT_IMPLIES(a_ptrs_meet, empty || full, wr_ptr_reg == rd_ptr_reg, "pointers apart")
    `LPS_ASSERT_ALWAYS(a_not_empty_and_full, !(empty && full), "queue both empty and full")

endmodule

@@ sv/lps_front.sv @@
`timescale 1ns / 1ps

module lps_front #(
    parameter int COORD_BITS = 12,
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic                         mode,
    input  logic signed [COORD_BITS-1:0] x_start,
    input  logic signed [COORD_BITS-1:0] y_start,
    input  logic signed [COORD_BITS-1:0] x_end,
    input  logic signed [COORD_BITS-1:0] y_end,
    input  logic                         cmd_pop,
    output logic                         cmd_empty,
    output logic [4*COORD_BITS+$bits(lps_pkg::cmd_flags_t)-1:0] cmd_data
);

    localparam int N  = COORD_BITS;
    localparam int FB = $bits(lps_pkg::cmd_flags_t);
    localparam int CMD_BITS = 4 * N + FB;

    logic signed [N:0]   dx, dy;
    logic [N:0]          dx_mag, dy_mag;
    logic [N-1:0]        adx, ady, den, add;
    lps_pkg::cmd_flags_t flags;
    logic [CMD_BITS-1:0] cmd_word;

    // Classify the item: deltas, step signs, major axis, major and minor magnitudes
    always_comb
    begin
        dx = $signed({x_end[N-1], x_end}) - $signed({x_start[N-1], x_start});
        dy = $signed({y_end[N-1], y_end}) - $signed({y_start[N-1], y_start});
        dx_mag = dx[N] ? (~dx + 1'b1) : dx;
        dy_mag = dy[N] ? (~dy + 1'b1) : dy;
        adx = dx_mag[N-1:0];
        ady = dy_mag[N-1:0];
        flags.mode    = mode;
        flags.x_major = (adx >= ady);
        flags.x_down  = dx[N];
        flags.y_down  = dy[N];
        den = flags.x_major ? adx : ady;
        add = flags.x_major ? ady : adx;
        cmd_word = {flags, x_start, y_start, den, add};
    end

    // Hold classified commands until the stepper takes them
    lps_queue #(
        .WIDTH (CMD_BITS),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .wdata (cmd_word),
        .full  (full),
        .pop   (cmd_pop),
        .rdata (cmd_data),
        .empty (cmd_empty)
    );

endmodule

@@ sv/lps_back.sv @@
`timescale 1ns / 1ps
`include "line_pixel_stepper_defines.svh"

module lps_back #(
    parameter int COORD_BITS = 12
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cmd_empty,
    input  logic [4*COORD_BITS+$bits(lps_pkg::cmd_flags_t)-1:0] cmd_data,
    output logic                      cmd_pop,
    input  logic                      res_full,
    output logic                      res_push,
    output logic [2*COORD_BITS+$bits(lps_pkg::res_flags_t)-1:0] res_data
);

    localparam int N  = COORD_BITS;
    localparam int A  = COORD_BITS + 1;
    localparam int FB = $bits(lps_pkg::cmd_flags_t);

    // Stepper state
    logic [N-1:0] cur_x_reg, cur_x_next;
    logic [N-1:0] cur_y_reg, cur_y_next;
    logic [A-1:0] accum_reg, accum_next;
    logic [N-1:0] denom_reg, denom_next;
    logic [N-1:0] addend_reg, addend_next;
    logic [N-1:0] pixels_left_reg, pixels_left_next;
    logic         x_major_reg, x_major_next;
    logic [1:0]   step_signs_reg, step_signs_next;
    logic         line_active_reg, line_active_next;

    lps_pkg::cmd_flags_t flags;
    lps_pkg::res_flags_t rflags;
    logic [N-1:0] c_x, c_y, c_den, c_add;
    logic [N-1:0] s_x, s_y, s_den, s_add, s_left;
    logic [A-1:0] s_acc, sum, acc_adv;
    logic         s_xm, s_xdn, s_ydn;
    logic         go, is_begin, idle_next, last, minor, step_x, step_y;
    logic [N-1:0] x_adv, y_adv, out_x, out_y;

    assign flags = lps_pkg::cmd_flags_t'(cmd_data[4*N+FB-1 -: FB]);
    assign c_x   = cmd_data[4*N-1 -: N];
    assign c_y   = cmd_data[3*N-1 -: N];
    assign c_den = cmd_data[2*N-1 -: N];
    assign c_add = cmd_data[N-1:0];

    // Take a command whenever one waits and the result queue has room
    assign go       = ~cmd_empty & ~res_full;
    assign cmd_pop  = go;
    assign res_push = go;

    always_comb
    begin
        is_begin  = (flags.mode == lps_pkg::MODE_BEGIN);
        idle_next = ~is_begin & ~line_active_reg;

        // Select the starting point for this pixel
        if (is_begin)
        begin
            s_x    = c_x;
            s_y    = c_y;
            s_den  = c_den;
            s_add  = c_add;
            s_acc  = {2'b00, c_den[N-1:1]};
            s_left = c_den;
            s_xm   = flags.x_major;
            s_xdn  = flags.x_down;
            s_ydn  = flags.y_down;
        end
        else
        begin
            s_x    = cur_x_reg;
            s_y    = cur_y_reg;
            s_den  = denom_reg;
            s_add  = addend_reg;
            s_acc  = accum_reg;
            s_left = pixels_left_reg - 1'b1;
            s_xm   = x_major_reg;
            s_xdn  = step_signs_reg[0];
            s_ydn  = step_signs_reg[1];
        end
        last = (s_left == '0);

        // Advance the error term and both coordinates
        sum     = s_acc + {1'b0, s_add};
        minor   = (sum >= {1'b0, s_den});
        acc_adv = minor ? (sum - {1'b0, s_den}) : sum;
        step_x  = s_xm | minor;
        step_y  = ~s_xm | minor;
        x_adv   = step_x ? (s_xdn ? s_x - 1'b1 : s_x + 1'b1) : s_x;
        y_adv   = step_y ? (s_ydn ? s_y - 1'b1 : s_y + 1'b1) : s_y;

        // Form the result; drop to zeros when no line is running
        rflags.valid = ~idle_next;
        rflags.last  = ~idle_next & last;
        out_x = idle_next ? '0 : s_x;
        out_y = idle_next ? '0 : s_y;

        // Hold state unless a pixel is produced
        cur_x_next       = cur_x_reg;
        cur_y_next       = cur_y_reg;
        accum_next       = accum_reg;
        denom_next       = denom_reg;
        addend_next      = addend_reg;
        pixels_left_next = pixels_left_reg;
        x_major_next     = x_major_reg;
        step_signs_next  = step_signs_reg;
        line_active_next = line_active_reg;
        if (go && !idle_next)
        begin
            cur_x_next       = last ? s_x : x_adv;
            cur_y_next       = last ? s_y : y_adv;
            accum_next       = last ? s_acc : acc_adv;
            denom_next       = s_den;
            addend_next      = s_add;
            pixels_left_next = s_left;
            x_major_next     = s_xm;
            step_signs_next  = {s_ydn, s_xdn};
            line_active_next = ~last;
        end
    end

    assign res_data = {rflags, out_x, out_y};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_x_reg       <= '0;
            cur_y_reg       <= '0;
            accum_reg       <= '0;
            denom_reg       <= '0;
            addend_reg      <= '0;
            pixels_left_reg <= '0;
            x_major_reg     <= 1'b0;
            step_signs_reg  <= '0;
            line_active_reg <= 1'b0;
        end
        else
        begin
            cur_x_reg       <= cur_x_next;
            cur_y_reg       <= cur_y_next;
            accum_reg       <= accum_next;
            denom_reg       <= denom_next;
            addend_reg      <= addend_next;
            pixels_left_reg <= pixels_left_next;
            x_major_reg     <= x_major_next;
            step_signs_reg  <= step_signs_next;
            line_active_reg <= line_active_next;
        end
    end

    `LPS_ASSERT_IMPLIES(a_active_has_pixels, line_active_reg, pixels_left_reg != '0, "active line with no pixels left")
    `LPS_ASSERT_IMPLIES(a_accum_below_denom, line_active_reg, accum_reg < {1'b0, denom_reg}, "error term not reduced")
    `LPS_ASSERT_ALWAYS(a_minor_not_above_major, addend_reg <= denom_reg, "minor delta exceeds major delta")

endmodule
